// ===== src/lab_pkg.sv =====
// Shared types and constants for the line assembly buffer.
package lab_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    localparam logic       CMD_ADD    = 1'b0;
    localparam logic       CMD_REMOVE = 1'b1;

    localparam logic [1:0] KIND_ADD_STATUS    = 2'd0;
    localparam logic [1:0] KIND_LINE_CHAR     = 2'd1;
    localparam logic [1:0] KIND_REMOVE_STATUS = 2'd2;

    localparam logic [7:0] NEWLINE_CODE      = 8'h0A;
    localparam logic [6:0] LIMIT_LOW         = 7'd2;
    localparam logic [6:0] LIMIT_HIGH        = 7'd64;
    localparam logic [6:0] LINE_LIMIT_RESET  = 7'd64;

endpackage

// ===== src/lab_if.sv =====
// Valid/ready channel interfaces for the command and result words.
interface lab_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface lab_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       ok;
    logic [7:0] line_char;
    logic       last;

    modport source (output valid, output kind, output ok, output line_char, output last,
                    input ready);
    modport sink   (input valid, input kind, input ok, input line_char, input last,
                    output ready);
endinterface

// ===== src/lab_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/line_assembly_buffer.sv =====
// Line assembly buffer: circular byte store that hands out newline-terminated lines.
//
//   Channel   Dir  Handshake        Word
//   i_in      in   valid/ready      cmd, data_byte
//   o_out     out  valid/ready      kind, ok, line_char, last
//   i_cfg_*   in   write enable     line_limit (7 bits)
//
// An add is answered by one status word. A remove starts a scan that reads the stored bytes
// one at a time through the byte memory's single read port: up to and including the newline,
// or line_limit-1 characters and a closing status word when there is none.
// A remove that finds no line answers with a status word without scanning.
// A stalled result word holds the scan; truncated bytes past the limit are skipped
// without stalling. Reset is synchronous and clears the fill, no memory pass is needed.
module line_assembly_buffer #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    lab_in_if.sink     i_in,
    lab_out_if.source  o_out
);
    import lab_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > 7) ? PW : 7;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [PW-1:0]  r_fill, n_fill;
    logic [PW-1:0]  r_nl_cnt, n_nl_cnt;
    logic [PW-1:0]  r_idx, n_idx;
    logic           r_found, n_found;
    logic [6:0]     r_line_limit;

    logic           r_out_valid;
    logic [1:0]     r_kind;
    logic           r_ok;
    logic [7:0]     r_char;
    logic           r_last;

    logic           w_load;
    logic [1:0]     w_kind;
    logic           w_ok;
    logic [7:0]     w_char;
    logic           w_last;

    logic           w_out_free;
    logic           w_accept;
    logic [6:0]     w_lim;
    logic [6:0]     w_lim_m1;
    logic           w_ram_we;
    logic           w_ram_re;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic [AW-1:0]  w_next_addr;
    logic [7:0]     w_rdata;
    logic [PW-1:0]  w_idx_inc;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
        logic [AW:0] cap;
        cap = (AW+1)'(CAPACITY);
        if (a >= cap) begin
            return AW'(a - cap);
        end
        return AW'(a);
    endfunction

    lab_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.data_byte),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_lim = (r_line_limit < LIMIT_LOW)  ? LIMIT_LOW :
                   (r_line_limit > LIMIT_HIGH) ? LIMIT_HIGH : r_line_limit;
    assign w_lim_m1    = w_lim - 7'd1;
    assign w_idx_inc   = r_idx + PW'(1);
    assign w_waddr     = wrap({1'b0, r_head} + (AW+1)'(r_fill));
    assign w_next_addr = wrap({1'b0, r_head} + (AW+1)'(w_idx_inc));

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_fill   = r_fill;
        n_nl_cnt = r_nl_cnt;
        n_idx    = r_idx;
        n_found  = r_found;
        w_ram_we = 1'b0;
        w_ram_re = 1'b0;
        w_raddr  = r_head;
        w_load   = 1'b0;
        w_kind   = KIND_ADD_STATUS;
        w_ok     = 1'b0;
        w_char   = 8'd0;
        w_last   = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.cmd == CMD_ADD) begin
                        w_load = 1'b1;
                        w_kind = KIND_ADD_STATUS;
                        if (CW'(r_fill) < CW'(CAPACITY)) begin
                            w_ok     = 1'b1;
                            w_ram_we = 1'b1;
                            n_fill   = r_fill + PW'(1);
                            if (i_in.data_byte == NEWLINE_CODE) begin
                                n_nl_cnt = r_nl_cnt + PW'(1);
                            end
                        end
                    end else if ((r_nl_cnt != '0) || (CW'(r_fill) >= CW'(w_lim))) begin
                        w_ram_re = 1'b1;
                        w_raddr  = r_head;
                        n_idx    = '0;
                        n_found  = (r_nl_cnt != '0);
                        n_state  = ST_SCAN;
                    end else begin
                        w_load = 1'b1;
                        w_kind = KIND_REMOVE_STATUS;
                    end
                end
            end
            ST_SCAN: begin
                w_raddr = w_next_addr;
                if (r_found && (w_rdata == NEWLINE_CODE)) begin
                    if (w_out_free) begin
                        w_load   = 1'b1;
                        w_kind   = KIND_REMOVE_STATUS;
                        w_ok     = 1'b1;
                        n_head   = wrap({1'b0, r_head} + (AW+1)'(w_idx_inc));
                        n_fill   = r_fill - w_idx_inc;
                        n_nl_cnt = r_nl_cnt - PW'(1);
                        n_state  = ST_IDLE;
                    end
                end else if (CW'(r_idx) < CW'(w_lim_m1)) begin
                    if (w_out_free) begin
                        w_load   = 1'b1;
                        w_kind   = KIND_LINE_CHAR;
                        w_char   = w_rdata;
                        w_last   = 1'b0;
                        n_idx    = w_idx_inc;
                        w_ram_re = 1'b1;
                    end
                end else if (r_found) begin
                    n_idx    = w_idx_inc;
                    w_ram_re = 1'b1;
                end else begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        w_kind  = KIND_REMOVE_STATUS;
                        w_ok    = 1'b1;
                        n_head  = wrap({1'b0, r_head} + (AW+1)'(w_lim_m1));
                        n_fill  = r_fill - PW'(w_lim_m1);
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_fill       <= '0;
            r_nl_cnt     <= '0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_line_limit <= LINE_LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_nl_cnt <= n_nl_cnt;
            r_idx    <= n_idx;
            r_found  <= n_found;
            if (i_cfg_we) begin
                r_line_limit <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= w_kind;
            r_ok   <= w_ok;
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_kind;
    assign o_out.ok        = r_ok;
    assign o_out.line_char = r_char;
    assign o_out.last      = r_last;
endmodule

// ===== src/lab_check.sv =====
// Port-level checker for the line assembly buffer and its bind statement.
module lab_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic       i_out_ok,
    input logic [7:0] i_out_line_char,
    input logic       i_out_last
);
    import lab_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result word dropped while stalled.");

    a_add_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_ADD) |=>
        i_out_valid && (i_out_kind == KIND_ADD_STATUS) && i_out_last)
        else $error("Add word did not produce its status word on the next cycle.");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_LINE_CHAR) |-> !i_out_last && !i_out_ok)
        else $error("Line character word carries ok or last.");

    a_status_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != KIND_LINE_CHAR) |-> (i_out_line_char == 8'd0) && i_out_last)
        else $error("Status word carries a character or lacks last.");

    a_busy_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_LINE_CHAR) |-> !i_in_ready)
        else $error("Input accepted while a line is still being emitted.");
endmodule

bind line_assembly_buffer lab_check u_lab_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_cmd        (i_in.cmd),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_kind      (o_out.kind),
    .i_out_ok        (o_out.ok),
    .i_out_line_char (o_out.line_char),
    .i_out_last      (o_out.last)
);

// ===== sim/line_assembly_buffer_tb.sv =====
// Self-checking testbench for the line assembly buffer: random traffic with a line predictor.
`timescale 1ns / 100ps

module line_assembly_buffer_tb;
    import lab_pkg::*;

    localparam int STORE_DEPTH    = 64;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       ok;
        logic [7:0] line_char;
        logic       last;
    } result_word_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [6:0] i_cfg_wdata;

    lab_in_if  cmd_ch ();
    lab_out_if res_ch ();

    line_assembly_buffer #(
        .CAPACITY (STORE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (cmd_ch),
        .o_out       (res_ch)
    );

    cmd_word_t    pending_words[$];
    result_word_t expected_words[$];
    cmd_word_t    next_word;
    result_word_t got_word;
    result_word_t want_word;

    logic [7:0] line_bytes [STORE_DEPTH];
    int         fill_model = 0;
    logic [6:0] limit_model = LINE_LIMIT_RESET;

    int tx_idle_pct = 29;
    int rx_idle_pct = 54;
    bit want_hold = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int words_sent = 0;
    int results_checked = 0;
    int lines_taken = 0;
    int adds_refused = 0;
    int limit_writes = 0;
    int mismatches = 0;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Computes the result words that one accepted command word must produce.
    task automatic assemble_expected(input logic cmd, input logic [7:0] data);
        int   lim;
        int   pos;
        int   n_emit;
        int   n_drop;
        bit   found;
        bit   taken;
        if (cmd == CMD_ADD) begin
            if (fill_model < STORE_DEPTH) begin
                line_bytes[fill_model] = data;
                fill_model++;
                expected_words.push_back('{KIND_ADD_STATUS, 1'b1, 8'h00, 1'b1});
            end else begin
                adds_refused++;
                expected_words.push_back('{KIND_ADD_STATUS, 1'b0, 8'h00, 1'b1});
            end
        end else begin
            lim = int'(limit_model);
            if (lim < int'(LIMIT_LOW)) lim = int'(LIMIT_LOW);
            if (lim > int'(LIMIT_HIGH)) lim = int'(LIMIT_HIGH);
            found = 1'b0;
            pos = 0;
            for (int i = 0; i < fill_model && !found; i++) begin
                if (line_bytes[i] == NEWLINE_CODE) begin
                    found = 1'b1;
                    pos = i;
                end
            end
            taken = 1'b1;
            n_emit = 0;
            n_drop = 0;
            if (found) begin
                n_emit = (pos < lim - 1) ? pos : lim - 1;
                n_drop = pos + 1;
            end else if (fill_model >= lim) begin
                n_emit = lim - 1;
                n_drop = lim - 1;
            end else begin
                taken = 1'b0;
            end
            for (int i = 0; i < n_emit; i++) begin
                expected_words.push_back('{KIND_LINE_CHAR, 1'b0, line_bytes[i], 1'b0});
            end
            if (taken) begin
                for (int i = 0; i + n_drop < fill_model; i++) begin
                    line_bytes[i] = line_bytes[i + n_drop];
                end
                fill_model -= n_drop;
                lines_taken++;
            end
            expected_words.push_back('{KIND_REMOVE_STATUS, taken, 8'h00, 1'b1});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.cmd       <= CMD_ADD;
            cmd_ch.data_byte <= 8'h00;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                assemble_expected(cmd_ch.cmd, cmd_ch.data_byte);
                words_sent++;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_word = pending_words.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.cmd       <= next_word.cmd;
                    cmd_ch.data_byte <= next_word.data_byte;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (want_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_word = '{res_ch.kind, res_ch.ok, res_ch.line_char, res_ch.last};
            results_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t ns: unexpected word kind=%0d ok=%0d char=%02h last=%0d",
                             $time, got_word.kind, got_word.ok, got_word.line_char,
                             got_word.last);
                end
            end else begin
                want_word = expected_words.pop_front();
                if (got_word.kind !== want_word.kind || got_word.ok !== want_word.ok ||
                    got_word.line_char !== want_word.line_char ||
                    got_word.last !== want_word.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t ns: exp k=%0d ok=%0d c=%02h l=%0d, got k=%0d ok=%0d c=%02h l=%0d",
                                 $time, want_word.kind, want_word.ok, want_word.line_char,
                                 want_word.last, got_word.kind, got_word.ok,
                                 got_word.line_char, got_word.last);
                    end
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_words.size());
        $display("FAILED: results differ");
        $finish;
    end

    task automatic queue_add(input logic [7:0] value);
        pending_words.push_back('{CMD_ADD, value});
    endtask

    task automatic queue_remove();
        pending_words.push_back('{CMD_REMOVE, 8'($urandom_range(255))});
    endtask

    // Queues len bytes that are never a newline, optionally followed by one.
    task automatic queue_line(input int len, input bit terminated);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (b == NEWLINE_CODE) b = 8'h8A;
            queue_add(b);
        end
        if (terminated) queue_add(NEWLINE_CODE);
    endtask

    task automatic queue_random(input int n_items);
        int made;
        int pick;
        int len;
        bit terminated;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = ($urandom_range(4) == 0) ? $urandom_range(70) : $urandom_range(10);
                terminated = ($urandom_range(9) != 0);
                queue_line(len, terminated);
                queue_remove();
                made += len + int'(terminated) + 1;
            end else if (pick < 85) begin
                queue_add(8'($urandom_range(255)));
                made++;
            end else begin
                queue_remove();
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || cmd_ch.valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_limit(input logic [6:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        limit_model = value;
        limit_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 7'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store, zero byte as data, a plain line and an empty line.
        queue_remove();
        queue_add(8'h00);
        queue_add(8'hFF);
        queue_add(NEWLINE_CODE);
        queue_remove();
        queue_add(NEWLINE_CODE);
        queue_remove();
        queue_remove();
        wait_drained();

        // A line longer than the limit, then a run without a newline.
        write_line_limit(7'd4);
        queue_add(8'h61);
        queue_add(8'h62);
        queue_add(8'h63);
        queue_add(8'h64);
        queue_add(8'h65);
        queue_add(NEWLINE_CODE);
        queue_remove();
        queue_add(8'h80);
        queue_add(8'h7F);
        queue_add(8'h00);
        queue_add(8'h55);
        queue_add(8'hAA);
        queue_remove();
        queue_remove();
        wait_drained();

        write_line_limit(7'd0);
        queue_random(20);
        wait_drained();

        // Overfill the store so that adds are refused.
        write_line_limit(7'd127);
        queue_line(STORE_DEPTH + 2, 1'b0);
        queue_remove();
        queue_remove();
        queue_random(15);
        wait_drained();

        tx_idle_pct = 54;
        rx_idle_pct = 29;
        write_line_limit(7'd2);
        queue_random(15);
        wait_drained();
        write_line_limit(7'd64);
        queue_random(20);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_line_limit(7'd1);
        want_hold = 1'b1;
        queue_random(20);
        wait_drained();
        write_line_limit(7'($urandom_range(3, 63)));
        queue_random(20);
        wait_drained();

        $display("Sent %0d command words across %0d line limit settings; checked %0d results.",
                 words_sent, limit_writes + 1, results_checked);
        $display("Lines taken: %0d, adds refused on a full store: %0d.",
                 lines_taken, adds_refused);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/lab_pkg.sv
src/lab_if.sv
src/lab_ram.sv
src/line_assembly_buffer.sv
src/lab_check.sv
sim/line_assembly_buffer_tb.sv
